FILE: design/cfp_pkg.sv
// Package for the CRC-32 frame parser: shared types, register and status codes,
// and the CRC-32 byte and word functions. Depends on nothing.

package cfp_pkg;

  localparam int unsigned CfgAddrW = 5;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_WIRE_MAGIC     = 3'd0;
  localparam reg_idx_t REG_MAX_PAYLOAD    = 3'd1;
  localparam reg_idx_t REG_TICK_TYPE      = 3'd2;
  localparam reg_idx_t REG_BAR_TYPE       = 3'd3;
  localparam reg_idx_t REG_HEARTBEAT_TYPE = 3'd4;
  localparam reg_idx_t REG_SUBSCRIBE_TYPE = 3'd5;
  localparam reg_idx_t REG_ACK_TYPE       = 3'd6;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;

  typedef enum logic [1:0] {
    PH_SEEK,
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_TOO_LARGE = 3'd1,
    ERR_BAD_CRC   = 3'd2,
    ERR_TRUNCATED = 3'd3,
    ERR_UNKNOWN   = 3'd4
  } err_t;

  typedef enum logic [2:0] {
    TIDX_TICK      = 3'd0,
    TIDX_BAR       = 3'd1,
    TIDX_HEARTBEAT = 3'd2,
    TIDX_SUBSCRIBE = 3'd3,
    TIDX_ACK       = 3'd4,
    TIDX_NONE      = 3'd5
  } tidx_t;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  // Configuration as seen by the parser core, plus the CRC seed of the magic.
  typedef struct packed {
    logic [31:0] wire_magic;
    logic [31:0] magic_seed;
    logic [15:0] max_payload;
    logic [23:0] tick_type;
    logic [23:0] bar_type;
    logic [7:0]  heartbeat_type;
    logic [23:0] subscribe_type;
    logic [23:0] ack_type;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        frame_ok;
    logic [2:0]  error_code;
    logic [7:0]  msg_type;
    logic [2:0]  type_index;
    logic [15:0] payload_length;
    logic [31:0] decoded_total;
    logic [31:0] rejected_total;
  } result_t;

  // One byte through the reflected CRC-32.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // Four bytes, low byte first, from the all-ones start value.
  function automatic logic [31:0] crc_word(input logic [31:0] w);
    logic [31:0] c;
    c = ALL_ONES;
    for (int i = 0; i < 4; i++) begin
      c = crc_byte(c, w[8*i +: 8]);
    end
    return c;
  endfunction

  localparam logic [31:0] MAGIC_SEED_RST = crc_word(32'd0);

endpackage

FILE: design/cfp_if.sv
// Stream interfaces of the CRC-32 frame parser: the byte input channel and
// the result channel. Depends on nothing.

interface cfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink (input valid, input byte_in, output ready);
endinterface

interface cfp_result_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic        frame_ok;
  logic [2:0]  error_code;
  logic [7:0]  msg_type;
  logic [2:0]  type_index;
  logic [15:0] payload_length;
  logic [31:0] decoded_total;
  logic [31:0] rejected_total;

  modport source (output valid, output kind, output data_byte, output frame_ok,
                  output error_code, output msg_type, output type_index,
                  output payload_length, output decoded_total,
                  output rejected_total, input ready);
  modport sink (input valid, input kind, input data_byte, input frame_ok,
                input error_code, input msg_type, input type_index,
                input payload_length, input decoded_total,
                input rejected_total, output ready);
endinterface

FILE: design/crc32_frame_parser_unit.sv
// CRC-32 frame parser, top level. A transferred byte passes through the input register and
// then the result register, where any result it causes waits to transfer.
// Throughput: one byte per cycle, set by the combinational CRC byte step and header
// compares between the input and result registers; stalls only on output back-pressure.
// Reset (rst_n, synchronous, active low) clears the frame state, counters and
// pipeline valids and loads the register defaults; no clearing pass is needed.

module crc32_frame_parser_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  cfp_byte_if.sink                     in_ch,
  cfp_result_if.source                 out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cfp_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  // Register set shared by the core. The magic's CRC seed travels with it, so
  // a matched magic loads the running CRC in one step.
  cfp_pkg::cfg_t cfg;

  cfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // The core holds each transferred byte in its input register and processes it
  // as soon as the result register is free or being emptied. While a result
  // waits unread, the held byte waits with it and the input stalls; with the
  // receiver ready, a byte moves through in every cycle.
  cfp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

FILE: design/cfp_regs.sv
// Configuration register file of the CRC-32 frame parser with its APB-style
// write and read port. Depends on cfp_pkg.

module cfp_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cfp_pkg::CfgAddrW-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output cfp_pkg::cfg_t                cfg
);

  logic [31:0] wire_magic_r;
  logic [31:0] magic_seed_r;
  logic [15:0] max_payload_r;
  logic [23:0] tick_type_r;
  logic [23:0] bar_type_r;
  logic [7:0]  heartbeat_type_r;
  logic [23:0] subscribe_type_r;
  logic [23:0] ack_type_r;

  logic             wr_en;
  cfp_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[cfp_pkg::CfgAddrW-1:2];

  // The CRC seed of the magic is worked out as the magic is written, so the
  // parser never has to run four bytes through the CRC at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wire_magic_r     <= 32'd0;
      magic_seed_r     <= cfp_pkg::MAGIC_SEED_RST;
      max_payload_r    <= 16'd1024;
      tick_type_r      <= 24'h010000;
      bar_type_r       <= 24'h020000;
      heartbeat_type_r <= 8'd3;
      subscribe_type_r <= 24'h040000;
      ack_type_r       <= 24'h050000;
    end else if (wr_en) begin
      case (idx)
        cfp_pkg::REG_WIRE_MAGIC: begin
          wire_magic_r <= pwdata;
          magic_seed_r <= cfp_pkg::crc_word(pwdata);
        end
        cfp_pkg::REG_MAX_PAYLOAD:    max_payload_r    <= pwdata[15:0];
        cfp_pkg::REG_TICK_TYPE:      tick_type_r      <= pwdata[23:0];
        cfp_pkg::REG_BAR_TYPE:       bar_type_r       <= pwdata[23:0];
        cfp_pkg::REG_HEARTBEAT_TYPE: heartbeat_type_r <= pwdata[7:0];
        cfp_pkg::REG_SUBSCRIBE_TYPE: subscribe_type_r <= pwdata[23:0];
        cfp_pkg::REG_ACK_TYPE:       ack_type_r       <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cfp_pkg::REG_WIRE_MAGIC:     prdata = wire_magic_r;
      cfp_pkg::REG_MAX_PAYLOAD:    prdata = {16'd0, max_payload_r};
      cfp_pkg::REG_TICK_TYPE:      prdata = {8'd0, tick_type_r};
      cfp_pkg::REG_BAR_TYPE:       prdata = {8'd0, bar_type_r};
      cfp_pkg::REG_HEARTBEAT_TYPE: prdata = {24'd0, heartbeat_type_r};
      cfp_pkg::REG_SUBSCRIBE_TYPE: prdata = {8'd0, subscribe_type_r};
      cfp_pkg::REG_ACK_TYPE:       prdata = {8'd0, ack_type_r};
      default:                     prdata = 32'd0;
    endcase
  end

  assign cfg.wire_magic     = wire_magic_r;
  assign cfg.magic_seed     = magic_seed_r;
  assign cfg.max_payload    = max_payload_r;
  assign cfg.tick_type      = tick_type_r;
  assign cfg.bar_type       = bar_type_r;
  assign cfg.heartbeat_type = heartbeat_type_r;
  assign cfg.subscribe_type = subscribe_type_r;
  assign cfg.ack_type       = ack_type_r;

endmodule

FILE: design/cfp_core.sv
// Parser core of the CRC-32 frame parser: input register, frame state machine,
// per-byte CRC step and result register. Depends on cfp_pkg and cfp_if.

module cfp_core (
  input  logic            clk,
  input  logic            rst_n,
  input  cfp_pkg::cfg_t   cfg,
  cfp_byte_if.sink        in_ch,
  cfp_result_if.source    out_ch
);

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       fire;

  // Frame state
  cfp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] win_r, win_nxt;
  logic [2:0]  fill_r, fill_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rcv_r, rcv_nxt;
  logic [31:0] decoded_r, decoded_nxt;
  logic [31:0] rejected_r, rejected_nxt;

  // Result stage
  logic              out_valid_r;
  cfp_pkg::result_t  res_r;
  cfp_pkg::result_t  res;
  logic              res_valid;

  // Shared decode
  logic [7:0]  b;
  logic [2:0]  fill_inc;
  logic [31:0] win_shift;
  logic        magic_hit;
  logic [15:0] len_hdr;
  logic        hdr_last;
  logic        too_big;
  logic [15:0] cnt_inc;
  logic        pay_last;
  logic [31:0] rcv_shift;
  logic        trl_last;
  logic        crc_bad;
  logic [31:0] crc_step;
  cfp_pkg::tidx_t tidx;
  logic [15:0] min_len;

  assign fire        = s1_valid_r & (~out_valid_r | out_ch.ready);
  assign in_ch.ready = ~s1_valid_r | fire;

  assign b         = s1_byte_r;
  assign fill_inc  = fill_r[2] ? fill_r : fill_r + 3'd1;
  assign win_shift = {b, win_r[31:8]};
  assign magic_hit = fill_inc[2] & (win_shift == cfg.wire_magic);
  assign len_hdr   = {b, len_r[7:0]};
  assign hdr_last  = (count_r != 16'd0) & (count_r != 16'd1);
  assign too_big   = len_hdr > cfg.max_payload;
  assign cnt_inc   = count_r + 16'd1;
  assign pay_last  = cnt_inc >= len_r;
  assign rcv_shift = {b, rcv_r[31:8]};
  assign trl_last  = cnt_inc >= 16'd4;
  assign crc_bad   = rcv_shift != ~crc_r;
  assign crc_step  = cfp_pkg::crc_byte(crc_r, b);

  // Type lookup in priority order; the first register holding the code wins.
  always_comb begin
    if (type_r == cfg.tick_type[23:16]) begin
      tidx    = cfp_pkg::TIDX_TICK;
      min_len = cfg.tick_type[15:0];
    end else if (type_r == cfg.bar_type[23:16]) begin
      tidx    = cfp_pkg::TIDX_BAR;
      min_len = cfg.bar_type[15:0];
    end else if (type_r == cfg.heartbeat_type) begin
      tidx    = cfp_pkg::TIDX_HEARTBEAT;
      min_len = 16'd0;
    end else if (type_r == cfg.subscribe_type[23:16]) begin
      tidx    = cfp_pkg::TIDX_SUBSCRIBE;
      min_len = cfg.subscribe_type[15:0];
    end else if (type_r == cfg.ack_type[23:16]) begin
      tidx    = cfp_pkg::TIDX_ACK;
      min_len = cfg.ack_type[15:0];
    end else begin
      tidx    = cfp_pkg::TIDX_NONE;
      min_len = 16'd0;
    end
  end

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      case (phase_r)
        cfp_pkg::PH_SEEK: begin
          if (magic_hit) phase_nxt = cfp_pkg::PH_HEADER;
        end
        cfp_pkg::PH_HEADER: begin
          if (hdr_last) begin
            if (too_big) phase_nxt = cfp_pkg::PH_SEEK;
            else if (len_hdr != 16'd0) phase_nxt = cfp_pkg::PH_PAYLOAD;
            else phase_nxt = cfp_pkg::PH_TRAILER;
          end
        end
        cfp_pkg::PH_PAYLOAD: begin
          if (pay_last) phase_nxt = cfp_pkg::PH_TRAILER;
        end
        cfp_pkg::PH_TRAILER: begin
          if (trl_last) phase_nxt = cfp_pkg::PH_SEEK;
        end
        default: phase_nxt = cfp_pkg::PH_SEEK;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    logic           status;
    cfp_pkg::err_t  err;

    win_nxt      = win_r;
    fill_nxt     = fill_r;
    count_nxt    = count_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    crc_nxt      = crc_r;
    rcv_nxt      = rcv_r;
    decoded_nxt  = decoded_r;
    rejected_nxt = rejected_r;
    status       = 1'b0;
    err          = cfp_pkg::ERR_NONE;
    res_valid    = 1'b0;
    res          = '0;

    if (fire) begin
      case (phase_r)
        cfp_pkg::PH_SEEK: begin
          win_nxt  = win_shift;
          fill_nxt = fill_inc;
          if (magic_hit) begin
            crc_nxt   = cfg.magic_seed;
            count_nxt = 16'd0;
          end
        end
        cfp_pkg::PH_HEADER: begin
          crc_nxt = crc_step;
          if (count_r == 16'd0) begin
            type_nxt  = b;
            count_nxt = 16'd1;
          end else if (count_r == 16'd1) begin
            len_nxt   = {8'd0, b};
            count_nxt = 16'd2;
          end else begin
            len_nxt   = len_hdr;
            count_nxt = 16'd0;
            if (too_big) begin
              status = 1'b1;
              err    = cfp_pkg::ERR_TOO_LARGE;
            end
          end
        end
        cfp_pkg::PH_PAYLOAD: begin
          crc_nxt        = crc_step;
          count_nxt      = pay_last ? 16'd0 : cnt_inc;
          res_valid      = 1'b1;
          res.kind       = cfp_pkg::KIND_PAYLOAD;
          res.data_byte  = b;
        end
        cfp_pkg::PH_TRAILER: begin
          rcv_nxt   = rcv_shift;
          count_nxt = cnt_inc;
          if (trl_last) begin
            status = 1'b1;
            if (crc_bad) err = cfp_pkg::ERR_BAD_CRC;
            else if (tidx == cfp_pkg::TIDX_NONE) err = cfp_pkg::ERR_UNKNOWN;
            else if (len_r < min_len) err = cfp_pkg::ERR_TRUNCATED;
            else err = cfp_pkg::ERR_NONE;
          end
        end
        default: ;
      endcase

      if (status) begin
        if (err == cfp_pkg::ERR_NONE) decoded_nxt = decoded_r + 32'd1;
        else rejected_nxt = rejected_r + 32'd1;
        res_valid          = 1'b1;
        res.kind           = cfp_pkg::KIND_STATUS;
        res.frame_ok       = (err == cfp_pkg::ERR_NONE);
        res.error_code     = err;
        res.msg_type       = type_r;
        res.type_index     = tidx;
        res.payload_length = len_nxt;
        res.decoded_total  = decoded_nxt;
        res.rejected_total = rejected_nxt;
        // Back to the magic hunt with an empty window and a fresh CRC.
        win_nxt   = 32'd0;
        fill_nxt  = 3'd0;
        count_nxt = 16'd0;
        crc_nxt   = cfp_pkg::ALL_ONES;
        rcv_nxt   = 32'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= cfp_pkg::PH_SEEK;
      win_r       <= 32'd0;
      fill_r      <= 3'd0;
      count_r     <= 16'd0;
      type_r      <= 8'd0;
      len_r       <= 16'd0;
      crc_r       <= cfp_pkg::ALL_ONES;
      rcv_r       <= 32'd0;
      decoded_r   <= 32'd0;
      rejected_r  <= 32'd0;
    end else begin
      if (in_ch.valid & in_ch.ready) s1_valid_r <= 1'b1;
      else if (fire) s1_valid_r <= 1'b0;

      if (fire & res_valid) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;

      phase_r    <= phase_nxt;
      win_r      <= win_nxt;
      fill_r     <= fill_nxt;
      count_r    <= count_nxt;
      type_r     <= type_nxt;
      len_r      <= len_nxt;
      crc_r      <= crc_nxt;
      rcv_r      <= rcv_nxt;
      decoded_r  <= decoded_nxt;
      rejected_r <= rejected_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid & in_ch.ready) s1_byte_r <= in_ch.byte_in;
    if (fire & res_valid) res_r <= res;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.data_byte      = res_r.data_byte;
  assign out_ch.frame_ok       = res_r.frame_ok;
  assign out_ch.error_code     = res_r.error_code;
  assign out_ch.msg_type       = res_r.msg_type;
  assign out_ch.type_index     = res_r.type_index;
  assign out_ch.payload_length = res_r.payload_length;
  assign out_ch.decoded_total  = res_r.decoded_total;
  assign out_ch.rejected_total = res_r.rejected_total;

endmodule
